// ----- rtl/core/vec3_normalize_unit_defines.svh -----
// Assertion macros shared by the vector normalization pipeline.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef VEC3_NORMALIZE_UNIT_DEFINES_SVH
`define VEC3_NORMALIZE_UNIT_DEFINES_SVH

// implication check sampled on the rising clock, off while reset is low
`define V3N_ASSERT_IMPL(label, clk_s, rstn_s, lhs, rhs, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (lhs) |-> (rhs)) \
        else $error(msg);

// next-cycle implication check
`define V3N_ASSERT_NEXT(label, clk_s, rstn_s, lhs, rhs, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ----- rtl/core/v3n_pkg.sv -----
// Shared constants and types for the vector normalization pipeline.
// No dependencies.
package v3n_pkg;

    localparam int COMPONENT_BITS_DEF     = 16;
    localparam int UNIT_FRACTION_BITS_DEF = 14;
    localparam int LENGTH_BITS            = 24;
    localparam int UNIT_OUT_BITS          = 16;

    // side data that rides beside each item through the pipeline
    typedef struct packed {
        logic       valid;
        logic       zero;
        logic [2:0] neg;
    } v3n_ctl_t;

endpackage

// ----- rtl/core/v3n_sqrt.sv -----
// Pipelined restoring square root: one result bit per stage.
// Depends on vec3_normalize_unit_defines.svh.
`include "vec3_normalize_unit_defines.svh"
module v3n_sqrt #(
    parameter int RAD_BITS  = 52,
    parameter int ROOT_BITS = 26,
    parameter int TAG_BITS  = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [RAD_BITS-1:0]  radicand,
    input  logic [TAG_BITS-1:0]  in_tag,
    output logic                 out_valid,
    output logic [ROOT_BITS-1:0] root,
    output logic [TAG_BITS-1:0]  out_tag
);
    localparam int REM_BITS = ROOT_BITS + 2;
    localparam int RADP     = 2 * ROOT_BITS;

    logic [RADP-1:0]      rad_reg  [0:ROOT_BITS];
    logic [REM_BITS-1:0]  rem_reg  [0:ROOT_BITS];
    logic [ROOT_BITS-1:0] root_reg [0:ROOT_BITS];
    logic [TAG_BITS-1:0]  tag_reg  [0:ROOT_BITS];
    logic [ROOT_BITS:0]   vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[ROOT_BITS-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg[0]  <= RADP'(radicand);
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        tag_reg[0]  <= in_tag;
    end

    for (genvar g = 0; g < ROOT_BITS; g++)
    begin : g_stage
        logic [REM_BITS-1:0] rem_sh;
        logic [REM_BITS-1:0] trial;
        always_comb
        begin
            rem_sh = {rem_reg[g][REM_BITS-3:0], rad_reg[g][RADP-1 -: 2]};
            trial  = {root_reg[g], 2'b01};
        end
        always_ff @(posedge clk)
        begin
            rad_reg[g+1] <= rad_reg[g] << 2;
            tag_reg[g+1] <= tag_reg[g];
            if (rem_sh >= trial)
            begin
                rem_reg[g+1]  <= rem_sh - trial;
                root_reg[g+1] <= {root_reg[g][ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg[g+1]  <= rem_sh;
                root_reg[g+1] <= {root_reg[g][ROOT_BITS-2:0], 1'b0};
            end
        end
    end

    assign out_valid = vld_reg[ROOT_BITS];
    assign root      = root_reg[ROOT_BITS];
    assign out_tag   = tag_reg[ROOT_BITS];

    `V3N_ASSERT_NEXT(a_sqrt_valid_flow, clk, rst_n, in_valid, vld_reg[0], "sqrt lost an item")
    `V3N_ASSERT_IMPL(a_sqrt_root_bound, clk, rst_n, out_valid,
        root <= {1'b1, {(ROOT_BITS-1){1'b0}}} + {1'b0, {(ROOT_BITS-1){1'b1}}},
        "sqrt root out of range")
endmodule

// ----- rtl/core/v3n_div.sv -----
// Pipelined restoring divider: floor(num * 2^FRAC / den), clamped to 2^UF.
// Depends on vec3_normalize_unit_defines.svh; num is always at most den / 2^8.
`include "vec3_normalize_unit_defines.svh"
module v3n_div #(
    parameter int NUM_BITS = 16,
    parameter int DEN_BITS = 24,
    parameter int FRAC     = 22,
    parameter int UF       = 14,
    parameter int TAG_BITS = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    input  logic [TAG_BITS-1:0] in_tag,
    output logic                out_valid,
    output logic [UF:0]         quo,
    output logic [TAG_BITS-1:0] out_tag
);
    // the integer part a/d is 0 or 1, so the first stage handles it
    localparam int STAGES = FRAC + 1;
    localparam int RB     = DEN_BITS + 1;
    localparam int QB     = FRAC + 2;

    logic [RB-1:0]       r_reg   [0:STAGES];
    logic [QB-1:0]       q_reg   [0:STAGES];
    logic [DEN_BITS-1:0] d_reg   [0:STAGES];
    logic [TAG_BITS-1:0] t_reg   [0:STAGES];
    logic [STAGES:0]     vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STAGES-1:0], in_valid};
        end
    end

    // hold the numerator beside its divisor so both advance together
    always_ff @(posedge clk)
    begin
        r_reg[0] <= RB'(num);
        q_reg[0] <= '0;
        d_reg[0] <= den;
        t_reg[0] <= in_tag;
    end

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        logic [RB-1:0] r_sh;
        always_comb
        begin
            if (g == 0)
                r_sh = r_reg[g];
            else
                r_sh = {r_reg[g][RB-2:0], 1'b0};
        end
        always_ff @(posedge clk)
        begin
            d_reg[g+1] <= d_reg[g];
            t_reg[g+1] <= t_reg[g];
            if (r_sh >= RB'(d_reg[g]))
            begin
                r_reg[g+1] <= r_sh - RB'(d_reg[g]);
                q_reg[g+1] <= {q_reg[g][QB-2:0], 1'b1};
            end
            else
            begin
                r_reg[g+1] <= r_sh;
                q_reg[g+1] <= {q_reg[g][QB-2:0], 1'b0};
            end
        end
    end

    localparam logic [QB-1:0] ONE = QB'(1) << UF;

    assign quo       = (q_reg[STAGES] > ONE) ? ONE[UF:0] : q_reg[STAGES][UF:0];
    assign out_valid = vld_reg[STAGES];
    assign out_tag   = t_reg[STAGES];

    `V3N_ASSERT_IMPL(a_div_quo_bound, clk, rst_n, out_valid,
        quo <= ONE[UF:0], "quotient above one")
endmodule

// ----- rtl/core/vec3_normalize_unit.sv -----
// Top level of the 3-component vector normalization pipeline.
// Depends on v3n_pkg, v3n_sqrt, v3n_div and vec3_normalize_unit_defines.svh.
//
//   channel  handshake       payload
//   input    start / busy    in_x in_y in_z
//   result   done            unit_x unit_y unit_z length was_zero
//
// One item per cycle; busy is tied low. Magnitudes, squares and sum take one
// stage each, then one stage per bit of the root and of the quotient chains.
// Reset clears only the valid bits; nothing stalls.
`include "vec3_normalize_unit_defines.svh"
module vec3_normalize_unit #(
    parameter int COMPONENT_BITS     = v3n_pkg::COMPONENT_BITS_DEF,
    parameter int UNIT_FRACTION_BITS = v3n_pkg::UNIT_FRACTION_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [COMPONENT_BITS-1:0] in_x,
    input  logic signed [COMPONENT_BITS-1:0] in_y,
    input  logic signed [COMPONENT_BITS-1:0] in_z,
    output logic                             done,
    output logic signed [v3n_pkg::UNIT_OUT_BITS-1:0] unit_x,
    output logic signed [v3n_pkg::UNIT_OUT_BITS-1:0] unit_y,
    output logic signed [v3n_pkg::UNIT_OUT_BITS-1:0] unit_z,
    output logic [v3n_pkg::LENGTH_BITS-1:0] length,
    output logic                             was_zero
);
    localparam int CB   = COMPONENT_BITS;
    localparam int UF   = UNIT_FRACTION_BITS;
    localparam int SQB  = 2 * CB;
    localparam int SB   = SQB + 2;           // sum of three squares
    localparam int RB   = (SB + 16 + 1) / 2; // root bits of s * 2^16
    localparam int TAGB = 3 * CB + 1 + 3;
    localparam int LB   = v3n_pkg::LENGTH_BITS;
    localparam int OB   = v3n_pkg::UNIT_OUT_BITS;

    assign busy = 1'b0;

    // stage 1: magnitudes
    logic [CB-1:0] mag_next [0:2];
    logic [CB-1:0] mag_reg  [0:2];
    logic [2:0]    neg_next;
    logic [2:0]    neg_reg;
    logic          v1_reg;

    always_comb
    begin
        neg_next = {in_z[CB-1], in_y[CB-1], in_x[CB-1]};
        mag_next[0] = in_x[CB-1] ? CB'(-in_x) : in_x;
        mag_next[1] = in_y[CB-1] ? CB'(-in_y) : in_y;
        mag_next[2] = in_z[CB-1] ? CB'(-in_z) : in_z;
    end

    // stage 2: squares; stage 3: sum
    logic [SQB-1:0] sq_reg [0:2];
    logic [CB-1:0]  mag2_reg [0:2];
    logic [2:0]     neg2_reg;
    logic           v2_reg;
    logic [SB-1:0]  sum_reg;
    logic [CB-1:0]  mag3_reg [0:2];
    logic [2:0]     neg3_reg;
    logic           v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start & ~busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        neg2_reg <= neg_reg;
        neg3_reg <= neg2_reg;
        for (int i = 0; i < 3; i++)
        begin
            mag_reg[i]  <= mag_next[i];
            sq_reg[i]   <= mag_reg[i] * mag_reg[i];
            mag2_reg[i] <= mag_reg[i];
            mag3_reg[i] <= mag2_reg[i];
        end
        sum_reg <= SB'(sq_reg[0]) + SB'(sq_reg[1]) + SB'(sq_reg[2]);
    end

    // root pipeline carries magnitudes, zero flag and signs as tag
    logic [2*RB-1:0] radicand;
    logic [TAGB-1:0] tag_in;
    logic [TAGB-1:0] tag_out;
    logic            rv;
    logic [RB-1:0]   root;

    assign radicand = (2*RB)'({sum_reg, 16'b0});
    assign tag_in   = {mag3_reg[2], mag3_reg[1], mag3_reg[0], sum_reg == '0, neg3_reg};

    v3n_sqrt #(.RAD_BITS(2*RB), .ROOT_BITS(RB), .TAG_BITS(TAGB)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .radicand  (radicand),
        .in_tag    (tag_in),
        .out_valid (rv),
        .root      (root),
        .out_tag   (tag_out)
    );

    logic          zero_t;
    logic [2:0]    neg_t;
    logic [RB-1:0] den;
    assign zero_t = tag_out[3];
    assign neg_t  = tag_out[2:0];
    // a zero vector divides by one; its quotients are dropped anyway
    assign den    = zero_t ? RB'(1) : root;

    localparam int LTAG = LB + 4;
    logic [LTAG-1:0] ltag_in;
    assign ltag_in = {LB'(root), zero_t, neg_t};

    logic [UF:0]     quo [0:2];
    logic [2:0]      dv;
    logic [LTAG-1:0] ltag [0:2];

    for (genvar c = 0; c < 3; c++)
    begin : g_div
        v3n_div #(
            .NUM_BITS (CB),
            .DEN_BITS (RB),
            .FRAC     (UF + 8),
            .UF       (UF),
            .TAG_BITS (LTAG)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (rv),
            .num       (tag_out[4 + c*CB +: CB]),
            .den       (den),
            .in_tag    (ltag_in),
            .out_valid (dv[c]),
            .quo       (quo[c]),
            .out_tag   (ltag[c])
        );
    end

    // output register
    v3n_pkg::v3n_ctl_t ctl;
    assign ctl = '{valid: dv[0], zero: ltag[0][3], neg: ltag[0][2:0]};

    logic          done_reg;
    logic [OB-1:0] ux_reg, uy_reg, uz_reg;
    logic [LB-1:0] len_reg;
    logic          zero_reg;

    function automatic logic [OB-1:0] apply_sign(input logic [UF:0] q, input logic n,
                                                 input logic z);
        logic [OB-1:0] w;
        w = OB'(q);
        if (z)
            return '0;
        return n ? OB'(-w) : w;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        ux_reg   <= apply_sign(quo[0], ctl.neg[0], ctl.zero);
        uy_reg   <= apply_sign(quo[1], ctl.neg[1], ctl.zero);
        uz_reg   <= apply_sign(quo[2], ctl.neg[2], ctl.zero);
        len_reg  <= ctl.zero ? '0 : ltag[0][LTAG-1:4];
        zero_reg <= ctl.zero;
    end

    assign done     = done_reg;
    assign unit_x   = ux_reg;
    assign unit_y   = uy_reg;
    assign unit_z   = uz_reg;
    assign length   = len_reg;
    assign was_zero = zero_reg;

    `V3N_ASSERT_IMPL(a_lanes_aligned, clk, rst_n, dv[0], dv[1] && dv[2],
        "divider lanes out of step")
    `V3N_ASSERT_IMPL(a_zero_clean, clk, rst_n, done && was_zero,
        length == '0 && unit_x == '0, "zero vector result not clean")
    `V3N_ASSERT_NEXT(a_done_follows, clk, rst_n, dv[0], done, "result strobe lost")
endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for vec3_normalize_unit: drives vectors, predicts length and
// unit vector with exact integer math, and compares every result as it comes out.
// Depends on v3n_pkg and the vec3_normalize_unit RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic signed [15:0] uz;
        logic [v3n_pkg::LENGTH_BITS-1:0] len;
        logic zero;
    } unit_result_t;

    localparam int UNIT_ONE = 1 << v3n_pkg::UNIT_FRACTION_BITS_DEF;
    localparam int DRAIN_CYCLES = 80;
    localparam longint CYCLE_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic signed [15:0] in_x = '0, in_y = '0, in_z = '0;
    logic busy, done, was_zero;
    logic signed [15:0] unit_x, unit_y, unit_z;
    logic [v3n_pkg::LENGTH_BITS-1:0] length;

    unit_result_t pending_units[$];
    int mismatches = 0;
    int idle_pct = 0;
    longint cycles = 0;

    vec3_normalize_unit DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .in_x(in_x), .in_y(in_y), .in_z(in_z), .done(done),
        .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
        .length(length), .was_zero(was_zero)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // floor(sqrt(s * 2^16)) by bisection on exact integers
    function automatic longint scaled_length(longint s);
        longint lo, hi, mid, target;
        begin
            target = s << 16;
            lo = 0;
            hi = 64'd1 << 25;
            while (hi - lo > 1)
            begin
                mid = (lo + hi) / 2;
                if (mid * mid <= target) lo = mid;
                else hi = mid;
            end
            return lo;
        end
    endfunction

    function automatic unit_result_t normalize(logic signed [15:0] x, logic signed [15:0] y,
                                               logic signed [15:0] z);
        unit_result_t r;
        longint m[3];
        longint s, len, q;
        logic neg[3];
        begin
            m[0] = x; m[1] = y; m[2] = z;
            s = 0;
            for (int i = 0; i < 3; i++)
            begin
                neg[i] = m[i] < 0;
                if (neg[i]) m[i] = -m[i];
                s += m[i] * m[i];
            end
            r = '0;
            if (s == 0)
            begin
                r.zero = 1'b1;
                return r;
            end
            len = scaled_length(s);
            r.len = len[v3n_pkg::LENGTH_BITS-1:0];
            for (int i = 0; i < 3; i++)
            begin
                q = (m[i] << (v3n_pkg::UNIT_FRACTION_BITS_DEF + 8)) / len;
                if (q > UNIT_ONE) q = UNIT_ONE;
                if (neg[i]) q = -q;
                if (i == 0) r.ux = q[15:0];
                else if (i == 1) r.uy = q[15:0];
                else r.uz = q[15:0];
            end
            return r;
        end
    endfunction

    // start stays high across back-to-back items; idle cycles drop it
    task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z);
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
            start <= 1'b1;
            in_x <= x;
            in_y <= y;
            in_z <= z;
            @(posedge clk);
            while (busy) @(posedge clk);
            pending_units.push_back(normalize(x, y, z));
            @(negedge clk);
        end
    endtask

    // draw one vector: random, small, single axis or extremes
    task automatic send_random_vector();
        logic signed [15:0] v[3];
        int shape;
        begin
            shape = $urandom_range(5);
            for (int i = 0; i < 3; i++)
            begin
                v[i] = 16'($urandom);
                if (shape == 0) v[i] = 16'(int'($urandom_range(15)) - 8);
                else if (shape == 1 && i != 0) v[i] = '0;
                else if (shape == 2) v[i] = ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
            end
            send_vector(v[0], v[1], v[2]);
        end
    endtask

    always @(posedge clk)
    begin
        unit_result_t got, want;
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            got = '{unit_x, unit_y, unit_z, length, was_zero};
            if (pending_units.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end
            else
            begin
                want = pending_units.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch expected %p actual %p", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_directed();
        begin
            idle_pct = 0;
            send_vector(0, 0, 0);
            send_vector(16'sh7fff, 0, 0);
            send_vector(16'sh8000, 0, 0);
            send_vector(0, 16'sh8000, 0);
            send_vector(0, 0, 16'sh7fff);
            send_vector(16'sh8000, 16'sh8000, 16'sh8000);
            send_vector(16'sh7fff, 16'sh7fff, 16'sh7fff);
            send_vector(16'sh7fff, 16'sh8000, 16'sh7fff);
            send_vector(1, 0, 0);
            send_vector(-1, 0, 0);
            send_vector(0, 0, -1);
            send_vector(1, 1, 1);
            send_vector(-1, -1, -1);
            send_vector(3, 4, 0);
            send_vector(-16'sd5461, 16'sd21845, -16'sd10923);
            send_vector(16'sh5555, 16'shaaaa, 16'sh0f0f);
        end
    endtask

    task automatic test_random_phase(int pct, int count);
        begin
            idle_pct = pct;
            repeat (count) send_random_vector();
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_phase(0, 120);
        test_random_phase(68, 100);
        test_random_phase(7, 100);
        test_random_phase(0, 80);
        start <= 1'b0;
        while (pending_units.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
